### src/char_lcd_command_sequencer_assert.svh
// Assertion macros for the character LCD command sequencer.
// Depends on nothing; included by files that check their own logic.
`ifndef CHAR_LCD_COMMAND_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_COMMAND_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define CLCD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clcd assertion failed");
// Next-cycle implication.
`define CLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clcd assertion failed");
`else
`define CLCD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define CLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/clcd_pkg.sv
// Shared types, codes and the power-up sequence table for the LCD sequencer.
// No dependencies.
package clcd_pkg;

    // Operation codes
    localparam logic [3:0] OP_INIT       = 4'd0;
    localparam logic [3:0] OP_CHAR       = 4'd1;
    localparam logic [3:0] OP_SET_CURSOR = 4'd2;
    localparam logic [3:0] OP_CLEAR      = 4'd3;
    localparam logic [3:0] OP_HOME       = 4'd4;
    localparam logic [3:0] OP_DISPLAY    = 4'd5;
    localparam logic [3:0] OP_CURSOR_VIS = 4'd6;
    localparam logic [3:0] OP_BLINK      = 4'd7;
    localparam logic [3:0] OP_ENTRY_MODE = 4'd8;
    localparam logic [3:0] OP_SHIFT_CUR  = 4'd9;
    localparam logic [3:0] OP_SHIFT_DISP = 4'd10;

    // Controller command bytes
    localparam logic [7:0] CMD_WAKE      = 8'h30;
    localparam logic [7:0] CMD_FUNC_8BIT = 8'h38;
    localparam logic [7:0] CMD_FUNC_4BIT = 8'h20;
    localparam logic [7:0] CMD_FUNC_4B2L = 8'h28;
    localparam logic [7:0] CMD_ONOFF     = 8'h08;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_ENTRY_INC = 8'h06;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_DDRAM     = 8'h80;
    localparam logic [7:0] CMD_SHIFT     = 8'h10;
    localparam logic [7:0] CMD_ENTRY     = 8'h04;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_SHIFT_DSP = 8'h18;

    // Row start offsets, modulo 128 (row 1 is -1)
    localparam logic [6:0] ROW1_OFFSET = 7'd127;
    localparam logic [6:0] ROW2_OFFSET = 7'd39;
    localparam logic [6:0] ROW3_OFFSET = 7'd19;
    localparam logic [6:0] ROW4_OFFSET = 7'd83;

    // Timing, microseconds
    localparam int unsigned T_EN_US       = 20;
    localparam int unsigned T_PWRUP_US    = 40000;
    localparam int unsigned T_WAKE1_US    = 5000;
    localparam int unsigned T_WAKE2_US    = 150;
    localparam int unsigned T_CMD_US      = 60;
    localparam int unsigned T_CLR_INIT_US = 4000;
    localparam int unsigned T_CLR_HOME_US = 2000;

    localparam logic [15:0] HOLD_EN        = 16'(T_EN_US);
    localparam logic [15:0] HOLD_PWRUP     = 16'(T_PWRUP_US);
    localparam logic [15:0] HOLD_BAD_ROW   = 16'(T_CMD_US);
    localparam logic [15:0] HOLD_WAKE1     = 16'(T_EN_US + T_WAKE1_US);
    localparam logic [15:0] HOLD_WAKE2     = 16'(T_EN_US + T_WAKE2_US);
    localparam logic [15:0] HOLD_CMD       = 16'(T_EN_US + T_CMD_US);
    localparam logic [15:0] HOLD_CLR_INIT  = 16'(T_EN_US + T_CLR_INIT_US);
    localparam logic [15:0] HOLD_CLR_HOME  = 16'(T_EN_US + T_CLR_HOME_US);

    // Last step of the power-up list per bus width
    localparam logic [3:0] INIT_LAST_8 = 4'd8;
    localparam logic [3:0] INIT_LAST_4 = 4'd9;

    localparam int unsigned QUEUE_DEPTH = 4;

    // Job kinds carried from front to back
    typedef enum logic [1:0] {
        JOB_IDLE   = 2'd0,  // one EN-low event, pins zero
        JOB_STROBE = 2'd1,  // one EN pulse with the pins as given
        JOB_BYTE   = 2'd2   // a full byte: one pulse (8-bit) or two nibbles
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic        rs;
        logic [7:0]  data;
        logic [15:0] hold;  // hold of the job's final event
        logic        last;  // final job of the operation
    } job_t;

    typedef struct packed {
        logic [3:0] opcode;
        logic [7:0] character;
        logic [2:0] row_number;
        logic [6:0] column_number;
        logic       flag_a;
        logic       flag_b;
    } in_item_t;

    typedef struct packed {
        logic        register_select;
        logic [7:0]  data_pins;
        logic        enable_level;
        logic [15:0] hold_us;
        logic        last_event;
    } out_event_t;

    function automatic job_t make_job(job_kind_t kind, logic [7:0] data,
                                      logic [15:0] hold, logic last);
        job_t j;
        j.kind = kind;
        j.rs   = 1'b0;
        j.data = data;
        j.hold = hold;
        j.last = last;
        return j;
    endfunction

    // Power-up sequence, one job per step
    function automatic job_t init_job(logic [3:0] step, logic eight);
        job_t       j;
        logic [3:0] t;
        t = (!eight && step > 4'd5) ? step - 4'd1 : step;
        case (step)
            4'd0: j = make_job(JOB_IDLE, 8'h00, HOLD_PWRUP, 1'b0);
            4'd1: j = make_job(JOB_STROBE, CMD_WAKE, HOLD_WAKE1, 1'b0);
            4'd2,
            4'd3: j = make_job(JOB_STROBE, CMD_WAKE, HOLD_WAKE2, 1'b0);
            4'd4: j = make_job(JOB_STROBE, eight ? CMD_FUNC_8BIT : CMD_FUNC_4BIT,
                               HOLD_CMD, 1'b0);
            default: begin
                if (!eight && step == 4'd5) begin
                    j = make_job(JOB_BYTE, CMD_FUNC_4B2L, HOLD_CMD, 1'b0);
                end else begin
                    case (t)
                        4'd5:    j = make_job(JOB_BYTE, CMD_ONOFF, HOLD_CMD, 1'b0);
                        4'd6:    j = make_job(JOB_BYTE, CMD_CLEAR, HOLD_CLR_INIT, 1'b0);
                        4'd7:    j = make_job(JOB_BYTE, CMD_ENTRY_INC, HOLD_CMD, 1'b0);
                        default: j = make_job(JOB_BYTE, CMD_DISP_ON, HOLD_CMD, 1'b1);
                    endcase
                end
            end
        endcase
        return j;
    endfunction

endpackage

### src/clcd_front.sv
// Front end: accepts operations, keeps the on/off flags, queues byte jobs.
// Depends on clcd_pkg.
module clcd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              bus_eight_bit,
    input  logic              s_valid,
    output logic              s_ready,
    input  clcd_pkg::in_item_t s_data,
    output logic              push_valid,
    input  logic              push_ready,
    output clcd_pkg::job_t    push_job
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_INIT
    } state_t;

    state_t         state_reg, state_next;
    logic [3:0]     step_reg, step_next;
    clcd_pkg::job_t job_reg, job_next;
    logic           disp_reg, disp_next;
    logic           curs_reg, curs_next;
    logic           blink_reg, blink_next;

    logic           op_known;
    clcd_pkg::job_t op_job;
    logic [6:0]     row_off;
    logic           row_ok;
    logic [3:0]     init_last;

    // Row to address offset
    always_comb begin
        row_ok  = 1'b1;
        row_off = clcd_pkg::ROW1_OFFSET;
        unique case (s_data.row_number)
            3'd1:    row_off = clcd_pkg::ROW1_OFFSET;
            3'd2:    row_off = clcd_pkg::ROW2_OFFSET;
            3'd3:    row_off = clcd_pkg::ROW3_OFFSET;
            3'd4:    row_off = clcd_pkg::ROW4_OFFSET;
            default: row_ok  = 1'b0;
        endcase
    end

    // Decode one operation; flags take their new values first
    always_comb begin
        disp_next  = disp_reg;
        curs_next  = curs_reg;
        blink_next = blink_reg;
        op_known   = 1'b1;
        op_job     = clcd_pkg::make_job(clcd_pkg::JOB_BYTE, 8'h00, clcd_pkg::HOLD_CMD, 1'b1);
        unique case (s_data.opcode)
            clcd_pkg::OP_INIT: begin
                disp_next  = 1'b1;
                curs_next  = 1'b0;
                blink_next = 1'b0;
            end
            clcd_pkg::OP_CHAR: begin
                op_job.rs   = 1'b1;
                op_job.data = s_data.character;
            end
            clcd_pkg::OP_SET_CURSOR: begin
                if (row_ok) begin
                    op_job.data = clcd_pkg::CMD_DDRAM
                                | {1'b0, 7'(s_data.column_number + row_off)};
                end else begin
                    op_job.kind = clcd_pkg::JOB_IDLE;
                    op_job.hold = clcd_pkg::HOLD_BAD_ROW;
                end
            end
            clcd_pkg::OP_CLEAR: begin
                op_job.data = clcd_pkg::CMD_CLEAR;
                op_job.hold = clcd_pkg::HOLD_CLR_HOME;
            end
            clcd_pkg::OP_HOME: begin
                op_job.data = clcd_pkg::CMD_HOME;
                op_job.hold = clcd_pkg::HOLD_CLR_HOME;
            end
            clcd_pkg::OP_DISPLAY:    disp_next  = s_data.flag_a;
            clcd_pkg::OP_CURSOR_VIS: curs_next  = s_data.flag_a;
            clcd_pkg::OP_BLINK:      blink_next = s_data.flag_a;
            clcd_pkg::OP_ENTRY_MODE: begin
                op_job.data = clcd_pkg::CMD_ENTRY | {6'd0, s_data.flag_a, s_data.flag_b};
            end
            clcd_pkg::OP_SHIFT_CUR: begin
                op_job.data = clcd_pkg::CMD_SHIFT | {5'd0, s_data.flag_a, 2'd0};
            end
            clcd_pkg::OP_SHIFT_DISP: begin
                op_job.data = clcd_pkg::CMD_SHIFT_DSP | {5'd0, s_data.flag_a, 2'd0};
            end
            default: op_known = 1'b0;
        endcase
        if (s_data.opcode == clcd_pkg::OP_DISPLAY
                || s_data.opcode == clcd_pkg::OP_CURSOR_VIS
                || s_data.opcode == clcd_pkg::OP_BLINK) begin
            op_job.data = clcd_pkg::CMD_ONOFF | {5'd0, disp_next, curs_next, blink_next};
        end
    end

    assign init_last  = bus_eight_bit ? clcd_pkg::INIT_LAST_8 : clcd_pkg::INIT_LAST_4;
    assign s_ready    = (state_reg == ST_IDLE);
    assign push_valid = (state_reg != ST_IDLE);
    assign push_job   = (state_reg == ST_PUSH) ? job_reg
                                               : clcd_pkg::init_job(step_reg, bus_eight_bit);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        job_next   = job_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && op_known) begin
                    if (s_data.opcode == clcd_pkg::OP_INIT) begin
                        state_next = ST_INIT;
                        step_next  = 4'd0;
                    end else begin
                        state_next = ST_PUSH;
                        job_next   = op_job;
                    end
                end
            end
            ST_PUSH: begin
                if (push_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_INIT: begin
                if (push_ready) begin
                    step_next = step_reg + 4'd1;
                    if (step_reg == init_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= 4'd0;
            disp_reg  <= 1'b0;
            curs_reg  <= 1'b0;
            blink_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (s_valid && s_ready) begin
                disp_reg  <= disp_next;
                curs_reg  <= curs_next;
                blink_reg <= blink_next;
            end
        end
        job_reg <= job_next;
    end

endmodule

### src/clcd_queue.sv
// Small job queue between the front and back ends.
// Depends on clcd_pkg.
module clcd_queue #(
    parameter int unsigned DEPTH = clcd_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  clcd_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output clcd_pkg::job_t pop_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    clcd_pkg::job_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### src/clcd_back.sv
// Back end: expands each job into EN strobes and drives the event register.
// Depends on clcd_pkg.
module clcd_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 bus_eight_bit,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  clcd_pkg::job_t       pop_job,
    output logic                 m_valid,
    input  logic                 m_ready,
    output clcd_pkg::out_event_t m_data
);

    clcd_pkg::job_t       job_reg;
    logic                 busy_reg;
    logic [1:0]           idx_reg;
    logic                 m_valid_reg;
    clcd_pkg::out_event_t m_data_reg;

    logic                 slot_free;
    logic                 fire;
    logic [1:0]           final_idx;
    logic                 is_final;
    clcd_pkg::out_event_t ev;

    assign pop_ready = !busy_reg;
    assign slot_free = !m_valid_reg || m_ready;
    assign fire      = busy_reg && slot_free;

    always_comb begin
        case (job_reg.kind)
            clcd_pkg::JOB_IDLE:   final_idx = 2'd0;
            clcd_pkg::JOB_STROBE: final_idx = 2'd1;
            default:              final_idx = bus_eight_bit ? 2'd1 : 2'd3;
        endcase
        is_final = (idx_reg == final_idx);

        ev.register_select = job_reg.rs;
        ev.enable_level    = (job_reg.kind != clcd_pkg::JOB_IDLE) && !idx_reg[0];
        ev.hold_us         = is_final ? job_reg.hold : clcd_pkg::HOLD_EN;
        ev.last_event      = is_final && job_reg.last;
        case (job_reg.kind)
            clcd_pkg::JOB_IDLE:   ev.data_pins = 8'h00;
            clcd_pkg::JOB_STROBE: ev.data_pins = job_reg.data;
            default: begin
                if (bus_eight_bit) begin
                    ev.data_pins = job_reg.data;
                end else if (idx_reg[1]) begin
                    ev.data_pins = {job_reg.data[3:0], 4'h0};
                end else begin
                    ev.data_pins = {job_reg.data[7:4], 4'h0};
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (!busy_reg && pop_valid) begin
                busy_reg <= 1'b1;
                idx_reg  <= 2'd0;
            end else if (fire) begin
                if (is_final) begin
                    busy_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (!busy_reg && pop_valid) begin
            job_reg <= pop_job;
        end
        if (fire) begin
            m_data_reg <= ev;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### src/char_lcd_command_sequencer.sv
// Top level of the character LCD command sequencer: front, queue, back.
// Depends on clcd_pkg, clcd_front, clcd_queue, clcd_back and the assert header.
//
//  Channel | Ports                         | Carries
//  --------+-------------------------------+------------------------------------
//  input   | s_valid  s_ready  s_data      | one LCD operation (in_item_t)
//  output  | m_valid  m_ready  m_data      | one bus event (out_event_t)
//  config  | cfg_valid cfg_ready cfg_data  | bus_eight_bit, always ready
//
// An operation is decoded combinationally on acceptance, and its byte jobs
// enter the queue at one per cycle while the queue has room. The back end
// emits one bus event per cycle while the sink keeps up, with a load step
// before the events of each job. A character write in 4-bit mode is four
// events; power-up init in 4-bit mode, the longest, is ten jobs and 29 events.
// A new operation is taken once the front has queued the last job of the
// previous one. Reset is synchronous and clears all control state.
`include "char_lcd_command_sequencer_assert.svh"

module char_lcd_command_sequencer #(
    parameter int unsigned QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // operation input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  clcd_pkg::in_item_t   s_data,
    // bus event output
    output logic                 m_valid,
    input  logic                 m_ready,
    output clcd_pkg::out_event_t m_data,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    // Bus width select; the user must write it only while the block is idle (not enforced)
    logic           bus_eight_bit_reg;

    logic           push_valid, push_ready;
    clcd_pkg::job_t push_job;
    logic           pop_valid, pop_ready;
    clcd_pkg::job_t pop_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_eight_bit_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            bus_eight_bit_reg <= cfg_data;
        end
    end

    // Front: classifies each operation and queues its byte jobs
    clcd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .bus_eight_bit (bus_eight_bit_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_job      (push_job)
    );

    // Queue decouples decode from the slow event stream
    clcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Back: turns each job into EN-high / EN-low event pairs, or one EN-low event for an idle job
    clcd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .bus_eight_bit (bus_eight_bit_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_job       (pop_job),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

    // An EN-high event is always the fixed pulse width and never ends an operation
    `CLCD_ASSERT_IMPLIES(a_en_pulse, aclk, aresetn, m_valid && m_data.enable_level, (m_data.hold_us == clcd_pkg::HOLD_EN) && !m_data.last_event)
    // The final event of an operation leaves EN low
    `CLCD_ASSERT_IMPLIES(a_last_en_low, aclk, aresetn, m_valid && m_data.last_event, !m_data.enable_level)
    // An unknown opcode is dropped and the front stays open
    `CLCD_ASSERT_NEXT(a_unknown_drop, aclk, aresetn, s_valid && s_ready && (s_data.opcode > clcd_pkg::OP_SHIFT_DISP), s_ready)

endmodule
